// ===== rtl/skyline_atlas_allocator_macros.svh =====
// assertion helpers for the skyline atlas allocator
`ifndef SKYLINE_ATLAS_ALLOCATOR_MACROS_SVH
`define SKYLINE_ATLAS_ALLOCATOR_MACROS_SVH

// same-cycle implication, off while in reset
`define SAA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SAA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/saa_pkg.sv =====
`default_nettype none
package saa_pkg;

    // default geometry
    localparam int unsigned SAA_SHEETS       = 2;
    localparam int unsigned SAA_SHEET_WIDTH  = 256;
    localparam int unsigned SAA_SHEET_HEIGHT = 256;

    // fixed field widths
    localparam int unsigned SAA_IN_W  = 9;
    localparam int unsigned SAA_POS_W = 8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_WRITE,
        ST_RESULT
    } saa_state_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } ctrl_stat_t;

    typedef struct packed {
        logic                 full;
        logic                 sheet;
        logic [SAA_POS_W-1:0] x;
        logic [SAA_POS_W-1:0] y;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/saa_ram.sv =====
`default_nettype none
module saa_ram #(
    parameter int unsigned WIDTH = 9,
    parameter int unsigned DEPTH = 512,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/saa_ctrl.sv =====
`default_nettype none
module saa_ctrl import saa_pkg::*; #(
    parameter int unsigned SHEETS       = SAA_SHEETS,
    parameter int unsigned SHEET_WIDTH  = SAA_SHEET_WIDTH,
    parameter int unsigned SHEET_HEIGHT = SAA_SHEET_HEIGHT,
    localparam int unsigned AW = $clog2(SHEETS * SHEET_WIDTH),
    localparam int unsigned HW = $clog2(SHEET_HEIGHT + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [SAA_IN_W-1:0] block_width,
    input  wire logic [SAA_IN_W-1:0] block_height,
    input  wire logic                res_take,
    output ctrl_stat_t               stat,
    output res_t                     res,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    input  wire logic [HW-1:0]       rd_data,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [HW-1:0]            wr_data
);

    localparam int unsigned DEPTH = SHEETS * SHEET_WIDTH;
    localparam int unsigned XW    = $clog2(SHEET_WIDTH);
    localparam int unsigned SIW   = (SHEETS > 1) ? $clog2(SHEETS) : 1;
    localparam int unsigned SUM_W = ((HW > SAA_IN_W) ? HW : SAA_IN_W) + 1;

    saa_state_t state_reg, state_next;

    logic [AW-1:0]       clr_reg;
    logic [SAA_IN_W-1:0] h_reg;
    logic [XW-1:0]       i_last_reg;
    logic [XW-1:0]       wm1_reg;
    logic [XW-1:0]       i_reg;
    logic [XW-1:0]       j_reg;
    logic [SIW-1:0]      sheet_reg;
    logic [AW-1:0]       base_reg;
    logic [HW-1:0]       level_reg;
    logic [XW-1:0]       spot_reg;
    logic                found_reg;
    logic                full_reg;
    logic [HW-1:0]       peak_reg;

    // tag of the read in flight
    logic                rd_valid_reg;
    logic                rd_first_reg;
    logic                rd_last_reg;
    logic [XW-1:0]       rd_i_reg;

    logic                too_wide;
    logic [SUM_W-1:0]    sum;
    logic                fits;
    logic                scan_wrap;
    logic                scan_end;
    logic                last_sheet;
    logic                clr_end;
    logic [HW-1:0]       pk;

    assign too_wide   = (block_width == '0) || (32'(block_width) >= SHEET_WIDTH);
    assign sum        = SUM_W'(level_reg) + SUM_W'(h_reg);
    assign fits       = found_reg && (sum <= SUM_W'(SHEET_HEIGHT));
    assign scan_wrap  = (j_reg == wm1_reg);
    assign scan_end   = scan_wrap && (i_reg == i_last_reg);
    assign last_sheet = (sheet_reg == SIW'(SHEETS - 1));
    assign clr_end    = (clr_reg == AW'(DEPTH - 1));
    assign pk         = (rd_first_reg || (rd_data > peak_reg)) ? rd_data : peak_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = too_wide ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (fits)
                begin
                    state_next = ST_WRITE;
                end
                else if (last_sheet)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_WRITE:
            begin
                if (scan_wrap)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        rd_en          = (state_reg == ST_SCAN);
        rd_addr        = base_reg + AW'(i_reg) + AW'(j_reg);
        wr_en          = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
        wr_addr        = (state_reg == ST_CLEAR) ? clr_reg
                                                 : base_reg + AW'(spot_reg) + AW'(j_reg);
        wr_data        = (state_reg == ST_CLEAR) ? '0 : HW'(sum);
        stat.idle      = (state_reg == ST_IDLE);
        stat.res_valid = (state_reg == ST_RESULT);
        res.full       = full_reg;
        res.sheet      = full_reg ? 1'b0 : 1'(sheet_reg);
        res.x          = full_reg ? '0 : SAA_POS_W'(spot_reg);
        res.y          = full_reg ? '0 : SAA_POS_W'(level_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_SCAN);
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_first_reg <= (j_reg == '0);
        rd_last_reg  <= scan_wrap;
        rd_i_reg     <= i_reg;

        // window max, judged when its last column arrives
        if (rd_valid_reg)
        begin
            peak_reg <= pk;
            if (rd_last_reg && (pk < level_reg))
            begin
                level_reg <= pk;
                spot_reg  <= rd_i_reg;
                found_reg <= 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    h_reg      <= block_height;
                    i_last_reg <= XW'(SHEET_WIDTH - 1 - 32'(block_width));
                    wm1_reg    <= XW'(32'(block_width) - 1);
                    sheet_reg  <= '0;
                    base_reg   <= '0;
                    i_reg      <= '0;
                    j_reg      <= '0;
                    level_reg  <= HW'(SHEET_HEIGHT);
                    found_reg  <= 1'b0;
                    full_reg   <= too_wide;
                end
            end
            ST_SCAN:
            begin
                if (scan_wrap)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + XW'(1);
                end
                else
                begin
                    j_reg <= j_reg + XW'(1);
                end
            end
            ST_DECIDE:
            begin
                if (fits)
                begin
                    j_reg    <= '0;
                    full_reg <= 1'b0;
                end
                else if (last_sheet)
                begin
                    full_reg <= 1'b1;
                end
                else
                begin
                    sheet_reg <= sheet_reg + SIW'(1);
                    base_reg  <= base_reg + AW'(SHEET_WIDTH);
                    i_reg     <= '0;
                    j_reg     <= '0;
                    level_reg <= HW'(SHEET_HEIGHT);
                    found_reg <= 1'b0;
                end
            end
            ST_WRITE:
            begin
                j_reg <= j_reg + XW'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/skyline_atlas_allocator.sv =====
`default_nettype none
`include "skyline_atlas_allocator_macros.svh"
// Skyline rectangle allocator over SHEETS atlas sheets of SHEET_WIDTH x
// SHEET_HEIGHT texels. Every column keeps its filled height in one
// synchronous RAM of SHEETS*SHEET_WIDTH entries. A request beat gives a
// block width and height; the sheets are tried in order, and in each the
// window of block_width columns is slid over start positions 0 to
// SHEET_WIDTH-block_width-1, keeping the first position with the lowest
// window maximum. On a fit the window columns are raised and the result
// beat gives sheet, x and y; otherwise full_res is set and the other
// fields are zero. One request is in work at a time. The scan reads one
// column per cycle through the single RAM read port; a placement then
// writes the block_width window columns, and the result is handed off
// before the return to idle. Widths of zero or of SHEET_WIDTH and above
// are answered without a scan. After reset the RAM is cleared one column
// per cycle, during which in_stall stays high. A finished result sits in
// an output register, so the next request is taken while it waits.
module skyline_atlas_allocator import saa_pkg::*; #(
    parameter int unsigned SHEETS       = SAA_SHEETS,
    parameter int unsigned SHEET_WIDTH  = SAA_SHEET_WIDTH,
    parameter int unsigned SHEET_HEIGHT = SAA_SHEET_HEIGHT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [SAA_IN_W-1:0]  block_width,
    input  wire logic [SAA_IN_W-1:0]  block_height,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      sheet_index,
    output logic [SAA_POS_W-1:0]      pos_x,
    output logic [SAA_POS_W-1:0]      pos_y,
    output logic                      full_res
);

    localparam int unsigned DEPTH = SHEETS * SHEET_WIDTH;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned HW    = $clog2(SHEET_HEIGHT + 1);

    // column height RAM port
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [HW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [HW-1:0] wr_data;

    ctrl_stat_t stat;
    res_t       res;
    logic       start;
    logic       res_take;

    // output register
    logic out_valid_reg, out_valid_next;
    res_t out_reg;

    // a request beat is taken only when the sequencer is idle
    assign in_stall = !stat.idle;
    assign start    = in_valid && !in_stall;

    // result moves on when the output register is empty or being drained
    assign res_take = stat.res_valid && (!out_valid_reg || !out_stall);

    saa_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    saa_ctrl #(
        .SHEETS       (SHEETS),
        .SHEET_WIDTH  (SHEET_WIDTH),
        .SHEET_HEIGHT (SHEET_HEIGHT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .block_width  (block_width),
        .block_height (block_height),
        .res_take     (res_take),
        .stat         (stat),
        .res          (res),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    always_comb
    begin
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sheet_index = out_reg.sheet;
    assign pos_x       = out_reg.x;
    assign pos_y       = out_reg.y;
    assign full_res    = out_reg.full;

    // the RAM port is never asked to read and write in the same cycle
    `SAA_ASSERT_IMPL(a_rd_wr_excl, clk, rst_n, rd_en, !wr_en, "read and write overlap")

    // a full answer carries no placement
    `SAA_ASSERT_IMPL(a_full_zero, clk, rst_n, out_valid && full_res,
        !sheet_index && (pos_x == '0) && (pos_y == '0), "full result with placement")

    // once a request is taken the block is busy with it
    `SAA_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start, in_stall, "idle after request")

endmodule
`default_nettype wire
